// File: rtl/wdd_pkg.sv
package wdd_pkg;

   localparam int STATUS_W = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int REQ_DATA_W = 96;
   localparam int HITS_W = 7;
   localparam int CONF_W = 17;
   localparam int PHRASE_W = 8;
   localparam int ENTRY_W = 121;

   localparam logic [STATUS_W-1:0] ST_NONE     = 4'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED   = 4'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 4'd2;
   localparam logic [STATUS_W-1:0] ST_COOLDOWN = 4'd3;
   localparam logic [STATUS_W-1:0] ST_FAILED   = 4'd4;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 4'd5;
   localparam logic [STATUS_W-1:0] ST_BAD      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 4'd7;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 4'd8;

   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HITS      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COOLDOWN  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT     = 2'd3;

   typedef struct packed {
      logic [31:0]         number;
      logic [31:0]         sequence_nr;
      logic [31:0]         time_ms;
      logic [PHRASE_W-1:0] phrase;
      logic [CONF_W-1:0]   confidence;
   } entry_type;

endpackage

// File: rtl/wdd_ram.sv
module wdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/wake_detection_debouncer_top.sv
// Wake-phrase debouncer with cooldown and an event queue. The block takes one word per
// cycle on req while rsp is not stalled and returns exactly one word on rsp for each, in
// order; a word's result passes through the first stage, written as the candidate and
// queue pointers update and the queue memory read issues, and then the output register.
// While a result waits on rsp the block takes one more word into its first stage and
// then holds req_tready low until rsp moves. Queued events sit in a single synchronous
// RAM of QUEUE_DEPTH entries whose registered read output feeds a pop's result in the
// first stage; a push and a later pop of the same slot never meet in one cycle.
// req_tuser is the mode (0 frame verdict, 1 pop); rsp_tuser is the status code.
module wake_detection_debouncer_top
   import wdd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_HITS = 100,
   localparam int FW = $clog2(QUEUE_DEPTH + 1),
   localparam int OW = ENTRY_W + FW,
   localparam int RSP_DATA_W = ((OW + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_ok, backend_failed, detected, phrase_id, confidence, confidence_finite,
   // frame_seq, captured_ms
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // event_number, event_sequence, event_time_ms, event_phrase, event_confidence,
   // queued_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = (FW > 5) ? FW : 5;
   localparam int SW = FW + 1;

   // configuration
   logic [16:0] thr_ff;
   logic [6:0]  req_hits_ff;
   logic [14:0] cooldown_ff;
   logic [4:0]  limit_ff;

   // candidate and queue control
   logic [PHRASE_W-1:0] cand_phrase_ff, cand_phrase_in;
   logic [CONF_W-1:0]   cand_peak_ff, cand_peak_in;
   logic [HITS_W-1:0]   hit_count_ff, hit_count_in;
   logic                have_ff, have_in;
   logic [31:0]         last_ms_ff, last_ms_in;
   logic [31:0]         last_number_ff, last_number_in;
   logic [HW-1:0]       head_ff, head_in;
   logic [FW-1:0]       fill_ff, fill_in;

   // pipeline
   logic                s1_valid_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   entry_type           s1_entry_ff;
   logic [FW-1:0]       s1_count_ff;
   logic                out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   entry_type           out_entry_ff;
   logic [FW-1:0]       out_count_ff;

   logic                req_accept, s1_move;
   logic                in_mode, in_ok, in_fail, in_det, in_finite;
   logic [PHRASE_W-1:0] in_phrase;
   logic [CONF_W-1:0]   in_conf;
   logic [31:0]         in_seq, in_ms;

   logic [STATUS_W-1:0] status_c;
   entry_type           entry_c, ram_dout, s1_result;
   logic                push_c, pop_c;
   logic                same_run;
   logic [HITS_W-1:0]   run_count, eff_hits;
   logic [CONF_W-1:0]   run_peak;
   logic [FW-1:0]       lim;
   logic                full;
   logic [32:0]         cool_end;
   logic                cool_hit;
   logic [SW-1:0]       slot_sum, drop_sum;
   logic [FW-1:0]       drop;
   logic [HW-1:0]       slot, drop_head, head_next;
   logic [OW-1:0]       rsp_vec;

   assign in_mode   = req_tuser;
   assign in_ok     = req_tdata[0];
   assign in_fail   = req_tdata[1];
   assign in_det    = req_tdata[2];
   assign in_phrase = req_tdata[10:3];
   assign in_conf   = req_tdata[27:11];
   assign in_finite = req_tdata[28];
   assign in_seq    = req_tdata[60:29];
   assign in_ms     = req_tdata[92:61];

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   // clamped settings
   always_comb begin
      if (req_hits_ff == '0) begin
         eff_hits = HITS_W'(1);
      end else if (req_hits_ff > HITS_W'(MAX_HITS)) begin
         eff_hits = HITS_W'(MAX_HITS);
      end else begin
         eff_hits = req_hits_ff;
      end
      if (limit_ff == '0) begin
         lim = FW'(1);
      end else if (CW'(limit_ff) > CW'(QUEUE_DEPTH)) begin
         lim = FW'(QUEUE_DEPTH);
      end else begin
         lim = FW'(CW'(limit_ff));
      end
   end

   // run tracking
   assign same_run  = (cand_phrase_ff != '0) && (cand_phrase_ff == in_phrase);
   assign run_count = !same_run ? HITS_W'(1) :
                      (hit_count_ff < HITS_W'(MAX_HITS)) ? hit_count_ff + HITS_W'(1) :
                      hit_count_ff;
   assign run_peak  = (!same_run || in_conf > cand_peak_ff) ? in_conf : cand_peak_ff;

   assign cool_end = {1'b0, last_ms_ff} + 33'(cooldown_ff);
   assign cool_hit = have_ff && ({1'b0, in_ms} < cool_end);

   // queue pointers; the slot sum, and the drop sum when the queue is full, stay below twice the depth
   assign full      = fill_ff >= lim;
   assign slot_sum  = SW'(fill_ff) + SW'(head_ff);
   assign slot      = (slot_sum >= SW'(QUEUE_DEPTH)) ?
                      HW'(slot_sum - SW'(QUEUE_DEPTH)) : HW'(slot_sum);
   assign drop      = fill_ff - lim + FW'(1);
   assign drop_sum  = SW'(drop) + SW'(head_ff);
   assign drop_head = (drop_sum >= SW'(QUEUE_DEPTH)) ?
                      HW'(drop_sum - SW'(QUEUE_DEPTH)) : HW'(drop_sum);
   assign head_next = (head_ff == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + HW'(1);

   always_comb begin
      cand_phrase_in = cand_phrase_ff;
      cand_peak_in   = cand_peak_ff;
      hit_count_in   = hit_count_ff;
      have_in        = have_ff;
      last_ms_in     = last_ms_ff;
      last_number_in = last_number_ff;
      head_in        = head_ff;
      fill_in        = fill_ff;
      status_c       = ST_NONE;
      push_c         = 1'b0;
      pop_c          = 1'b0;
      entry_c        = '0;
      if (in_mode) begin
         if (fill_ff == '0) begin
            status_c = ST_EMPTY;
         end else begin
            status_c = ST_POPPED;
            pop_c    = 1'b1;
            head_in  = head_next;
            fill_in  = fill_ff - FW'(1);
         end
      end else if (!in_ok) begin
         status_c = ST_BAD;
      end else if (in_fail || !in_det || in_phrase == '0 || !in_finite ||
                   in_conf < thr_ff) begin
         cand_phrase_in = '0;
         cand_peak_in   = '0;
         hit_count_in   = '0;
         if (in_fail) begin
            status_c = ST_FAILED;
         end else if (in_det && (in_phrase == '0 || !in_finite)) begin
            status_c = ST_INVALID;
         end
      end else if (run_count < eff_hits) begin
         cand_phrase_in = in_phrase;
         cand_peak_in   = run_peak;
         hit_count_in   = run_count;
      end else begin
         cand_phrase_in = '0;
         cand_peak_in   = '0;
         hit_count_in   = '0;
         if (cool_hit) begin
            status_c = ST_COOLDOWN;
         end else begin
            push_c              = 1'b1;
            status_c            = full ? ST_DROPPED : ST_QUEUED;
            head_in             = full ? drop_head : head_ff;
            fill_in             = full ? lim : fill_ff + FW'(1);
            last_number_in      = last_number_ff + 32'd1;
            have_in             = 1'b1;
            last_ms_in          = in_ms;
            entry_c.number      = last_number_ff + 32'd1;
            entry_c.sequence_nr = in_seq;
            entry_c.time_ms     = in_ms;
            entry_c.phrase      = in_phrase;
            entry_c.confidence  = run_peak;
         end
      end
   end

   wdd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (req_accept && push_c),
      .wr_addr (slot),
      .wr_data (entry_c),
      .rd_en   (req_accept && pop_c),
      .rd_addr (head_ff),
      .rd_data (ram_dout)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= 17'd32768;
         req_hits_ff <= 7'd1;
         cooldown_ff <= '0;
         limit_ff    <= 5'd16;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD: thr_ff      <= csr_wdata;
            CSR_HITS:      req_hits_ff <= csr_wdata[6:0];
            CSR_COOLDOWN:  cooldown_ff <= csr_wdata[14:0];
            CSR_LIMIT:     limit_ff    <= csr_wdata[4:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_phrase_ff <= '0;
         cand_peak_ff   <= '0;
         hit_count_ff   <= '0;
         have_ff        <= 1'b0;
         last_ms_ff     <= '0;
         last_number_ff <= '0;
         head_ff        <= '0;
         fill_ff        <= '0;
      end else if (req_accept) begin
         cand_phrase_ff <= cand_phrase_in;
         cand_peak_ff   <= cand_peak_in;
         hit_count_ff   <= hit_count_in;
         have_ff        <= have_in;
         last_ms_ff     <= last_ms_in;
         last_number_ff <= last_number_in;
         head_ff        <= head_in;
         fill_ff        <= fill_in;
      end
   end

   // popped words take their event from the ram output
   assign s1_result = (s1_status_ff == ST_POPPED) ? ram_dout : s1_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= status_c;
         s1_entry_ff  <= entry_c;
         s1_count_ff  <= fill_in;
      end
      if (s1_move) begin
         out_status_ff <= s1_status_ff;
         out_entry_ff  <= s1_result;
         out_count_ff  <= s1_count_ff;
      end
   end

   assign rsp_vec = {out_count_ff, out_entry_ff.confidence, out_entry_ff.phrase,
                     out_entry_ff.time_ms, out_entry_ff.sequence_nr, out_entry_ff.number};
   assign rsp_tdata  = RSP_DATA_W'(rsp_vec);
   assign rsp_tuser  = out_status_ff;
   assign rsp_tvalid = out_valid_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      HW'(QUEUE_DEPTH - 1) >= head_ff)
      else $error("queue head out of range");

   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      hit_count_ff <= HITS_W'(MAX_HITS))
      else $error("hit count above limit");

   a_bad_frame_hold: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !in_mode && !in_ok) |=>
         ($stable(cand_phrase_ff) && $stable(hit_count_ff) && $stable(fill_ff)))
      else $error("bad frame changed state");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import wdd_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_HITS = 100;
   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_POP = 1'b1;

   typedef struct packed {
      logic                mode;
      logic                frame_ok;
      logic                backend_failed;
      logic                detected;
      logic [PHRASE_W-1:0] phrase;
      logic [CONF_W-1:0]   conf;
      logic                finite;
      logic [31:0]         seq_nr;
      logic [31:0]         captured_ms;
   } req_word_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      entry_type           evt;
      logic [4:0]          count;
   } rsp_word_t;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [127:0]          rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wake_detection_debouncer_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .MAX_HITS(MAX_HITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   // register copies
   logic [16:0] cfg_threshold = 17'd32768;
   logic [6:0]  cfg_hits = 7'd1;
   logic [14:0] cfg_cooldown = 15'd0;
   logic [4:0]  cfg_limit = 5'd16;

   // debouncer state
   logic [PHRASE_W-1:0] cand_phrase;
   logic [CONF_W-1:0]   cand_peak;
   logic [6:0]          hit_count;
   logic                have_accepted;
   logic [31:0]         last_accept_ms;
   logic [31:0]         last_number;
   entry_type           ev_store [QUEUE_DEPTH];
   logic [3:0]          q_head;
   logic [4:0]          q_fill;

   req_word_t pending [$];
   rsp_word_t expected_rsp [$];
   req_word_t req_cur;
   rsp_word_t want;
   int        req_gap = 0;
   int        rsp_stall = 0;
   bit        idle_on = 1'b1;
   logic [31:0] now_ms = '0;

   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int n_queued = 0;
   int n_dropped = 0;
   int n_cool = 0;
   int n_popped = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      if (errors < 50)
         $display("word %0d %s: got %0h, expected %0h", words_checked, what, got, exp_val);
      errors++;
   endtask

   function automatic void clear_candidate();
      cand_phrase = '0;
      cand_peak = '0;
      hit_count = '0;
   endfunction

   function automatic rsp_word_t debounce_step(input req_word_t w);
      rsp_word_t   r;
      logic [3:0]  slot;
      logic [4:0]  lim;
      logic [4:0]  drop;
      logic [6:0]  need;
      logic [32:0] cool_end;
      r = '0;
      lim = (cfg_limit == 0) ? 5'd1 : (cfg_limit > QUEUE_DEPTH) ? 5'(QUEUE_DEPTH) : cfg_limit;
      need = (cfg_hits == 0) ? 7'd1 : (cfg_hits > MAX_HITS) ? 7'(MAX_HITS) : cfg_hits;
      cool_end = {1'b0, last_accept_ms} + {18'd0, cfg_cooldown};
      if (w.mode == MODE_POP) begin
         if (q_fill == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.status = ST_POPPED;
            r.evt = ev_store[q_head];
            q_head = q_head + 4'd1;
            q_fill = q_fill - 5'd1;
            n_popped++;
         end
      end else if (!w.frame_ok) begin
         r.status = ST_BAD;
      end else if (w.backend_failed) begin
         r.status = ST_FAILED;
         clear_candidate();
      end else if (!w.detected) begin
         r.status = ST_NONE;
         clear_candidate();
      end else if (w.phrase == 0 || !w.finite) begin
         r.status = ST_INVALID;
         clear_candidate();
      end else if (w.conf < cfg_threshold) begin
         r.status = ST_NONE;
         clear_candidate();
      end else begin
         if (cand_phrase == 0 || cand_phrase != w.phrase) begin
            cand_phrase = w.phrase;
            cand_peak = w.conf;
            hit_count = 7'd1;
         end else begin
            if (hit_count < MAX_HITS) hit_count = hit_count + 7'd1;
            if (w.conf > cand_peak) cand_peak = w.conf;
         end
         if (hit_count < need) begin
            r.status = ST_NONE;
         end else if (have_accepted && {1'b0, w.captured_ms} < cool_end) begin
            r.status = ST_COOLDOWN;
            clear_candidate();
            n_cool++;
         end else begin
            r.status = ST_QUEUED;
            if (q_fill >= lim) begin
               drop = q_fill - lim + 5'd1;
               q_head = q_head + drop[3:0];
               q_fill = q_fill - drop;
               r.status = ST_DROPPED;
               n_dropped++;
            end else begin
               n_queued++;
            end
            slot = q_head + q_fill[3:0];
            last_number = last_number + 32'd1;
            ev_store[slot].number = last_number;
            ev_store[slot].sequence_nr = w.seq_nr;
            ev_store[slot].time_ms = w.captured_ms;
            ev_store[slot].phrase = cand_phrase;
            ev_store[slot].confidence = cand_peak;
            r.evt = ev_store[slot];
            q_fill = q_fill + 5'd1;
            have_accepted = 1'b1;
            last_accept_ms = w.captured_ms;
            clear_candidate();
         end
      end
      r.count = q_fill;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         clear_candidate();
         have_accepted = 1'b0;
         last_accept_ms = '0;
         last_number = '0;
         q_head = '0;
         q_fill = '0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.insert(expected_rsp.size(), debounce_step(req_cur));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
               req_cur = pending[0];
               pending.delete(0);
               req_tvalid <= 1'b1;
               req_tuser <= req_cur.mode;
               req_tdata <= {3'b000, req_cur.captured_ms, req_cur.seq_nr, req_cur.finite,
                             req_cur.conf, req_cur.phrase, req_cur.detected,
                             req_cur.backend_failed, req_cur.frame_ok};
               if (idle_on && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected word, status", 32'(rsp_tuser), 32'd0);
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[31:0] !== want.evt.number)
                  report_mismatch("event_number", rsp_tdata[31:0], want.evt.number);
               if (rsp_tdata[63:32] !== want.evt.sequence_nr)
                  report_mismatch("event_sequence", rsp_tdata[63:32], want.evt.sequence_nr);
               if (rsp_tdata[95:64] !== want.evt.time_ms)
                  report_mismatch("event_time_ms", rsp_tdata[95:64], want.evt.time_ms);
               if (rsp_tdata[103:96] !== want.evt.phrase)
                  report_mismatch("event_phrase", 32'(rsp_tdata[103:96]), 32'(want.evt.phrase));
               if (rsp_tdata[120:104] !== want.evt.confidence)
                  report_mismatch("event_confidence", 32'(rsp_tdata[120:104]),
                                  32'(want.evt.confidence));
               if (rsp_tdata[125:121] !== want.count)
                  report_mismatch("queued_count", 32'(rsp_tdata[125:121]), 32'(want.count));
            end
            words_checked++;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0) rsp_stall = $urandom_range(1, 13);
         end
      end
   end

   task automatic add_frame(input logic ok, failed, det, input logic [7:0] phrase,
                            input logic [16:0] conf, input logic fin,
                            input logic [31:0] at_ms);
      req_word_t w;
      w.mode = MODE_FRAME;
      w.frame_ok = ok;
      w.backend_failed = failed;
      w.detected = det;
      w.phrase = phrase;
      w.conf = conf;
      w.finite = fin;
      w.seq_nr = $urandom;
      w.captured_ms = at_ms;
      pending.insert(pending.size(), w);
   endtask

   task automatic add_pop();
      req_word_t w;
      w.mode = MODE_POP;
      w.frame_ok = 1'($urandom_range(0, 1));
      w.backend_failed = 1'($urandom_range(0, 1));
      w.detected = 1'($urandom_range(0, 1));
      w.phrase = 8'($urandom_range(0, 255));
      w.conf = 17'($urandom_range(0, 131071));
      w.finite = 1'($urandom_range(0, 1));
      w.seq_nr = $urandom;
      w.captured_ms = $urandom;
      pending.insert(pending.size(), w);
   endtask

   function automatic logic [16:0] pass_conf();
      int unsigned top;
      top = (cfg_threshold <= 65536 && $urandom_range(0, 4) != 0) ? 65536 : 131071;
      return 17'($urandom_range(top, cfg_threshold));
   endfunction

   task automatic drain();
      do @(negedge clock);
      while (pending.size() != 0 || req_tvalid || expected_rsp.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_THRESHOLD: cfg_threshold = data;
         CSR_HITS:      cfg_hits = data[6:0];
         CSR_COOLDOWN:  cfg_cooldown = data[14:0];
         CSR_LIMIT:     cfg_limit = data[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [16:0] thr, input logic [16:0] hits,
                             input logic [16:0] cool, input logic [16:0] lim);
      drain();
      csr_write(CSR_THRESHOLD, thr);
      csr_write(CSR_HITS, hits);
      csr_write(CSR_COOLDOWN, cool);
      csr_write(CSR_LIMIT, lim);
   endtask

   task automatic gen_phase(input int n);
      int start;
      int len;
      int need;
      logic [7:0] p;
      start = pending.size();
      need = (cfg_hits == 0) ? 1 : (cfg_hits > MAX_HITS) ? MAX_HITS : cfg_hits;
      while (pending.size() - start < n) begin
         now_ms += $urandom_range(0, 400);
         p = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
                                           8'($urandom_range(1, 3));
         case ($urandom_range(0, 9))
            0, 1: add_pop();
            2, 3, 4, 5, 6: begin
               // run of hits on one phrase
               len = ($urandom_range(0, 9) < 6) ? need : $urandom_range(1, need + 1);
               repeat (len) begin
                  add_frame(1, 0, 1, p, pass_conf(), 1, now_ms);
                  now_ms += $urandom_range(0, 400);
               end
            end
            default: begin
               case ($urandom_range(0, 6))
                  0: add_frame(0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)), 17'($urandom_range(0, 131071)),
                               1'($urandom_range(0, 1)), $urandom);
                  1: add_frame(1, 1, 1'($urandom_range(0, 1)), p, pass_conf(), 1, now_ms);
                  2: add_frame(1, 0, 0, p, pass_conf(), 1, now_ms);
                  3: add_frame(1, 0, 1, 8'd0, pass_conf(), 1, now_ms);
                  4: add_frame(1, 0, 1, p, pass_conf(), 0, now_ms);
                  5: begin
                     if (cfg_threshold != 0)
                        add_frame(1, 0, 1, p, 17'($urandom_range(0, cfg_threshold - 1)), 1,
                                  now_ms);
                     else
                        add_frame(1, 0, 0, p, 17'($urandom_range(0, 131071)), 1, now_ms);
                  end
                  default: add_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                     17'($urandom_range(0, 131071)),
                                     1'($urandom_range(0, 1)), $urandom);
               endcase
            end
         endcase
      end
   endtask

   task automatic run_phase(input logic [16:0] thr, input logic [16:0] hits,
                            input logic [16:0] cool, input logic [16:0] lim,
                            input int n, input bit idle);
      set_config(thr, hits, cool, lim);
      idle_on = idle;
      gen_phase(n);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: every verdict kind but cooldown and drop, and the threshold edge
      add_pop();
      add_frame(0, 1, 1, 8'd255, 17'd131071, 1, 32'hFFFF_FFFF);
      add_frame(1, 1, 1, 8'd5, 17'd65536, 1, 32'd10);
      add_frame(1, 0, 0, 8'd5, 17'd65536, 1, 32'd20);
      add_frame(1, 0, 1, 8'd0, 17'd65536, 1, 32'd30);
      add_frame(1, 0, 1, 8'd7, 17'd65536, 0, 32'd40);
      add_frame(1, 0, 1, 8'd7, 17'd32767, 1, 32'd50);
      add_frame(1, 0, 1, 8'd255, 17'd32768, 1, 32'd60);
      add_frame(1, 0, 1, 8'd1, 17'd131071, 1, 32'hFFFF_FF00);
      add_pop();
      add_pop();
      add_pop();

      // cooldown end past 32 bits holds off wrapped timestamps
      set_config(17'd0, 17'd3, 17'd30000, 17'd1);
      add_frame(1, 0, 1, 8'd9, 17'd5, 1, 32'hFFFF_FF10);
      add_frame(1, 0, 1, 8'd9, 17'd100, 1, 32'hFFFF_FF20);
      add_frame(1, 0, 1, 8'd9, 17'd7, 1, 32'hFFFF_FF30);
      add_frame(1, 0, 1, 8'd9, 17'd0, 1, 32'd5);
      add_frame(1, 0, 1, 8'd9, 17'd0, 1, 32'd6);
      add_frame(1, 0, 1, 8'd9, 17'd0, 1, 32'h0000_7330);

      // zero hits and zero limit, threshold above one
      set_config(17'd131071, 17'd0, 17'd0, 17'd0);
      add_frame(1, 0, 1, 8'd2, 17'd131071, 1, 32'd100);
      add_frame(1, 0, 1, 8'd3, 17'd131071, 1, 32'd200);
      add_frame(1, 0, 1, 8'd3, 17'd65536, 1, 32'd300);
      add_pop();

      now_ms = 32'd1000;
      run_phase(17'd16384, 17'd2, 17'd500, 17'd4, 200, 1'b1);
      run_phase(17'd0, 17'd1, 17'd0, 17'd16, 200, 1'b1);
      run_phase(17'd65536, 17'd4, 17'd32767, 17'd2, 150, 1'b1);
      drain();
      now_ms = $urandom;
      run_phase(17'($urandom_range(0, 65536)), 17'd127, 17'd0, 17'd31, 300, 1'b1);
      drain();
      now_ms = 32'hFFFF_8000;
      run_phase(17'd131071, 17'd0, 17'd1000, 17'd0, 150, 1'b1);
      run_phase(17'd32768, 17'd3, 17'd200, 17'd8, 200, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      $display("checked %0d of %0d words: %0d events queued, %0d queued with drop,",
               words_checked, words_sent, n_queued, n_dropped);
      $display("%0d held by cooldown, %0d popped, under several register settings",
               n_cool, n_popped);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/wdd_pkg.sv
rtl/wdd_ram.sv
rtl/wake_detection_debouncer_top.sv
test/testbench.sv
